>>> rtl/sbpr_pkg.sv
// Shared types and constants for the servo bus packet receiver.
// No dependencies; every other file in rtl/ except sbpr_ram.sv uses this package.
`timescale 1ns / 1ps

package sbpr_pkg;

    localparam logic [7:0] HEADER_BYTE = 8'hFF;
    localparam logic [7:0] LENGTH_BIAS = 8'd2;

    // Parser position within a packet
    typedef enum logic [2:0] {
        FS_HDR1,
        FS_HDR2,
        FS_ID,
        FS_LEN,
        FS_INSTR,
        FS_BODY
    } front_state_t;

    // Result sequencer
    typedef enum logic [1:0] {
        BS_IDLE,
        BS_READ,
        BS_SHOW
    } back_state_t;

    // One checked packet waiting to be emitted
    typedef struct packed {
        logic [7:0] id;
        logic [7:0] instr;
        logic [7:0] count;
        logic       bank;
    } pkt_desc_t;

endpackage

>>> rtl/sbpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sbpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sbpr_front.sv
// Packet parser: takes bus bytes, stores parameters, checks the checksum
// and pushes a descriptor for each good packet. Uses sbpr_pkg.
`timescale 1ns / 1ps

module sbpr_front #(
    parameter int MAX_PARAMS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      rx_byte,
    input  logic                            q_full,
    output logic                            push,
    output sbpr_pkg::pkt_desc_t             push_desc,
    output logic                            wr_en,
    output logic [$clog2(2*MAX_PARAMS)-1:0] wr_addr,
    output logic [7:0]                      wr_data
);

    localparam int PW = $clog2(MAX_PARAMS + 1);
    localparam int AW = $clog2(2 * MAX_PARAMS);

    sbpr_pkg::front_state_t state_reg, state_next;
    logic [7:0]    id_reg, id_next;
    logic [7:0]    instr_reg, instr_next;
    logic [7:0]    count_reg, count_next;
    logic [7:0]    sum_reg, sum_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic          bank_reg, bank_next;
    logic          take;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbpr_pkg::FS_HDR1;
            bank_reg  <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bank_reg  <= bank_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        instr_reg <= instr_next;
        count_reg <= count_next;
        sum_reg   <= sum_next;
    end

    assign push_desc = '{id: id_reg, instr: instr_reg, count: count_reg, bank: bank_reg};

    assign wr_data = rx_byte;
    assign wr_addr = AW'(pos_reg) + (bank_reg ? AW'(MAX_PARAMS) : AW'(0));

    always_comb
    begin
        state_next = state_reg;
        id_next    = id_reg;
        instr_next = instr_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        pos_next   = pos_reg;
        bank_next  = bank_reg;
        push       = 1'b0;
        wr_en      = 1'b0;
        if (take)
        begin
            case (state_reg)
                sbpr_pkg::FS_HDR1:
                begin
                    if (rx_byte == sbpr_pkg::HEADER_BYTE)
                        state_next = sbpr_pkg::FS_HDR2;
                end
                sbpr_pkg::FS_HDR2:
                begin
                    state_next = (rx_byte == sbpr_pkg::HEADER_BYTE) ?
                                 sbpr_pkg::FS_ID : sbpr_pkg::FS_HDR1;
                end
                sbpr_pkg::FS_ID:
                begin
                    id_next    = rx_byte;
                    sum_next   = rx_byte;
                    state_next = sbpr_pkg::FS_LEN;
                end
                sbpr_pkg::FS_LEN:
                begin
                    count_next = rx_byte - sbpr_pkg::LENGTH_BIAS;
                    sum_next   = sum_reg + rx_byte;
                    pos_next   = '0;
                    state_next = sbpr_pkg::FS_INSTR;
                end
                sbpr_pkg::FS_INSTR:
                begin
                    instr_next = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    state_next = sbpr_pkg::FS_BODY;
                end
                sbpr_pkg::FS_BODY:
                begin
                    if (8'(pos_reg) >= count_reg)
                    begin
                        // checksum byte; a good packet claims the bank
                        if (~sum_reg == rx_byte)
                        begin
                            push      = 1'b1;
                            bank_next = !bank_reg;
                        end
                        state_next = sbpr_pkg::FS_HDR1;
                    end
                    else if (pos_reg >= PW'(MAX_PARAMS))
                    begin
                        // overflow: drop before storing
                        state_next = sbpr_pkg::FS_HDR1;
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        sum_next = sum_reg + rx_byte;
                        pos_next = pos_reg + PW'(1);
                    end
                end
                default:
                begin
                    state_next = sbpr_pkg::FS_HDR1;
                end
            endcase
        end
    end

endmodule

>>> rtl/sbpr_queue.sv
// Two-entry descriptor queue between parser and result sequencer.
// Uses sbpr_pkg.
`timescale 1ns / 1ps

module sbpr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sbpr_pkg::pkt_desc_t push_desc,
    input  logic                pop,
    output logic                full,
    output logic                head_valid,
    output sbpr_pkg::pkt_desc_t head_desc
);

    sbpr_pkg::pkt_desc_t entry_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_desc  = entry_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_desc;
    end

endmodule

>>> rtl/sbpr_back.sv
// Result sequencer: walks the stored parameters of the head packet and
// presents one result per parameter. Uses sbpr_pkg.
`timescale 1ns / 1ps

module sbpr_back #(
    parameter int MAX_PARAMS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  sbpr_pkg::pkt_desc_t             head_desc,
    output logic                            pop,
    output logic [$clog2(2*MAX_PARAMS)-1:0] rd_addr,
    input  logic [7:0]                      rd_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      servo_id,
    output logic [7:0]                      instruction_code,
    output logic [5:0]                      param_count,
    output logic [4:0]                      param_index,
    output logic [7:0]                      param_value,
    output logic                            has_param,
    output logic                            last
);

    localparam int PW = $clog2(MAX_PARAMS + 1);
    localparam int AW = $clog2(2 * MAX_PARAMS);

    sbpr_pkg::back_state_t state_reg, state_next;
    logic [PW-1:0] k_reg, k_next;
    logic [7:0]    value_reg, value_next;

    assign has_param        = (head_desc.count != 8'd0);
    assign last             = !has_param || ((8'(k_reg) + 8'd1) == head_desc.count);
    assign out_valid        = (state_reg == sbpr_pkg::BS_SHOW);
    assign servo_id         = head_desc.id;
    assign instruction_code = head_desc.instr;
    assign param_count      = 6'(head_desc.count);
    assign param_index      = 5'(k_reg);
    assign param_value      = value_reg;

    // read address follows the next index so data lands in BS_READ
    assign rd_addr = AW'(k_next) + (head_desc.bank ? AW'(MAX_PARAMS) : AW'(0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbpr_pkg::BS_IDLE;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        value_next = value_reg;
        pop        = 1'b0;
        case (state_reg)
            sbpr_pkg::BS_IDLE:
            begin
                k_next = '0;
                if (head_valid)
                begin
                    if (head_desc.count == 8'd0)
                    begin
                        value_next = 8'd0;
                        state_next = sbpr_pkg::BS_SHOW;
                    end
                    else
                    begin
                        state_next = sbpr_pkg::BS_READ;
                    end
                end
            end
            sbpr_pkg::BS_READ:
            begin
                value_next = rd_data;
                state_next = sbpr_pkg::BS_SHOW;
            end
            sbpr_pkg::BS_SHOW:
            begin
                if (out_ready)
                begin
                    if (last)
                    begin
                        pop        = 1'b1;
                        k_next     = '0;
                        state_next = sbpr_pkg::BS_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + PW'(1);
                        state_next = sbpr_pkg::BS_READ;
                    end
                end
            end
            default:
            begin
                state_next = sbpr_pkg::BS_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/servo_bus_packet_receiver_unit.sv
// Top level of the servo bus packet receiver: parser, descriptor queue,
// result sequencer and parameter RAM. Uses sbpr_pkg and all sbpr_* modules.
`timescale 1ns / 1ps

// Receives servo bus bytes (0xFF 0xFF id length instruction params checksum)
// one request per cycle on the input channel while in_ready is high, and for
// every packet whose checksum matches emits one result per parameter, in
// order, with last set on the final one; a packet without parameters gives
// a single result with has_param low. Bad headers, parameter overflow past
// MAX_PARAMS and bad checksums are dropped with no output. The parser takes
// one byte per cycle while in_ready is high. Parameters go into a two-bank
// RAM of 2*MAX_PARAMS bytes; each good packet claims a bank and a slot in a
// two-entry queue until its last result is taken. While both slots are held,
// in_ready is low. The sequencer starts each packet in BS_IDLE, then for each
// result does the registered RAM read in BS_READ and presents the value in
// BS_SHOW until out_ready takes it; an empty packet goes from BS_IDLE
// straight to BS_SHOW. No clearing pass is needed after reset.

module servo_bus_packet_receiver_unit #(
    parameter int MAX_PARAMS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] servo_id,
    output logic [7:0] instruction_code,
    output logic [5:0] param_count,
    output logic [4:0] param_index,
    output logic [7:0] param_value,
    output logic       has_param,
    output logic       last
);

    localparam int AW = $clog2(2 * MAX_PARAMS);

    logic                q_full;
    logic                q_push;
    logic                q_pop;
    logic                q_head_valid;
    sbpr_pkg::pkt_desc_t q_push_desc;
    sbpr_pkg::pkt_desc_t q_head_desc;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [7:0]          wr_data;
    logic [AW-1:0]       rd_addr;
    logic [7:0]          rd_data;

    sbpr_front #(
        .MAX_PARAMS(MAX_PARAMS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .push     (q_push),
        .push_desc(q_push_desc),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    sbpr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_push_desc),
        .pop       (q_pop),
        .full      (q_full),
        .head_valid(q_head_valid),
        .head_desc (q_head_desc)
    );

    // parameter storage: two banks of MAX_PARAMS bytes
    sbpr_ram #(
        .WIDTH(8),
        .DEPTH(2 * MAX_PARAMS)
    ) u_ram (
        .clk  (clk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    sbpr_back #(
        .MAX_PARAMS(MAX_PARAMS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_valid      (q_head_valid),
        .head_desc       (q_head_desc),
        .pop             (q_pop),
        .rd_addr         (rd_addr),
        .rd_data         (rd_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .servo_id        (servo_id),
        .instruction_code(instruction_code),
        .param_count     (param_count),
        .param_index     (param_index),
        .param_value     (param_value),
        .has_param       (has_param),
        .last            (last)
    );

    // The parser must never write into the bank the sequencer is reading.
    a_bank_split : assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && q_head_valid) |->
            ((wr_addr >= AW'(MAX_PARAMS)) != q_head_desc.bank))
        else $error("parameter write hit the bank being emitted");

    // A shown result always belongs to a queued packet.
    a_out_has_pkt : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> q_head_valid)
        else $error("result shown with empty descriptor queue");

    // An empty packet is a single result, so it must carry last.
    a_empty_last : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_param) |-> last)
        else $error("empty packet result without last");

    // A pop only happens when the final result is handed over.
    a_pop_on_last : assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (out_valid && out_ready && last))
        else $error("descriptor popped before final result taken");

endmodule
